// ----- src/telnet_gmcp_stream_filter_top_defines.svh -----
// Assertion macros for the telnet GMCP stream filter checker.
`ifndef TELNET_GMCP_STREAM_FILTER_TOP_DEFINES_SVH
`define TELNET_GMCP_STREAM_FILTER_TOP_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define GSF_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("gsf check failed");

// Next-cycle implication, disabled during reset.
`define GSF_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("gsf check failed");

`endif

// ----- src/gsf_pkg.sv -----
// Types and constants for the telnet GMCP stream filter.
package gsf_pkg;

  localparam logic [7:0] BYTE_IAC   = 8'hFF;
  localparam logic [7:0] BYTE_DONT  = 8'hFE;
  localparam logic [7:0] BYTE_DO    = 8'hFD;
  localparam logic [7:0] BYTE_WONT  = 8'hFC;
  localparam logic [7:0] BYTE_WILL  = 8'hFB;
  localparam logic [7:0] BYTE_SB    = 8'hFA;
  localparam logic [7:0] BYTE_SE    = 8'hF0;
  localparam logic [7:0] BYTE_SPACE = 8'h20;

  localparam logic [2:0] K_TEXT   = 3'd0;
  localparam logic [2:0] K_TEND   = 3'd1;
  localparam logic [2:0] K_PKG    = 3'd2;
  localparam logic [2:0] K_DATA   = 3'd3;
  localparam logic [2:0] K_COMMIT = 3'd4;
  localparam logic [2:0] K_ABORT  = 3'd5;
  localparam logic [2:0] K_REPLY  = 3'd6;

  localparam logic [7:0] CFG_REPLY_ENABLE = 8'd0;
  localparam logic [7:0] CFG_GMCP_OPTION  = 8'd1;

  localparam logic [7:0] GMCP_OPTION_RESET = 8'd201;

  localparam int RES_MAX = 4;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       end_of_call;
  } in_word_t;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] value;
    logic       last;
    logic       gmcp_on;
  } out_word_t;

  // Results of one input byte, handed from parser to result buffer.
  typedef struct packed {
    logic [2:0]                 count;
    logic [RES_MAX-1:0][2:0]    kind;
    logic [RES_MAX-1:0][7:0]    value;
    logic                       gmcp_on;
  } step_res_t;

endpackage

// ----- src/telnet_gmcp_stream_filter_top.sv -----
// Top level of the telnet GMCP stream filter.
// Channels: item (in_word_t: rx_byte, end_of_call) in with item_valid/item_ready;
// result (out_word_t: kind, value, last, gmcp_on) out with result_valid/result_ready;
// cfg writes with cfg_valid/cfg_ready, cfg_index 0 = reply_enable, 1 = gmcp_option,
// other indexes ignored. cfg_ready is always high.
// An accepted byte is registered in the input register, is parsed, and its
// zero to four result words load the result buffer once it is free; the first
// word is then presented from the result buffer.
// Words of one byte leave one per cycle while result_ready is high; the last carries last = 1. A byte
// with no result word leaves nothing.
// Throughput: one byte per cycle while each byte gives at most one word and
// the receiver takes every word; a byte with more words holds the input until
// the result buffer is down to its last word and that word is taken.
// Reset (rst, synchronous): parser returns to plain text, no text pending,
// GMCP not accepted, reply_enable = 1, gmcp_option = 201, buffers empty.
// When result_ready is low the current word holds; the input register fills
// and then item_ready drops until the buffer drains.
module telnet_gmcp_stream_filter_top import gsf_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       item_valid,
  output logic       item_ready,
  input  in_word_t   item,
  output logic       result_valid,
  input  logic       result_ready,
  output out_word_t  result,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [7:0] cfg_index,
  input  logic [7:0] cfg_data
);

  in_word_t   item_q;
  logic       item_q_valid;
  logic       buf_free;
  logic       fire;
  logic       reply_enable;
  logic [7:0] gmcp_option;
  step_res_t  step;

  assign fire       = item_q_valid && buf_free;
  assign item_ready = !item_q_valid || fire;
  assign cfg_ready  = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_q_valid <= 1'b0;
    end else if (item_valid && item_ready) begin
      item_q_valid <= 1'b1;
    end else if (fire) begin
      item_q_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && item_ready) begin
      item_q <= item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      reply_enable <= 1'b1;
      gmcp_option  <= GMCP_OPTION_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_REPLY_ENABLE: reply_enable <= cfg_data[0];
        CFG_GMCP_OPTION:  gmcp_option  <= cfg_data;
        default: ;
      endcase
    end
  end

  gsf_parser u_parser (
    .clk          (clk),
    .rst          (rst),
    .fire         (fire),
    .word         (item_q),
    .reply_enable (reply_enable),
    .gmcp_option  (gmcp_option),
    .res          (step)
  );

  gsf_res_buf u_res_buf (
    .clk       (clk),
    .rst       (rst),
    .load      (fire),
    .res       (step),
    .out_ready (result_ready),
    .out_valid (result_valid),
    .out_word  (result),
    .free      (buf_free)
  );

endmodule

// ----- src/gsf_parser.sv -----
// Telnet parse state and the per-byte result generation.
module gsf_parser import gsf_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      fire,
  input  in_word_t  word,
  input  logic      reply_enable,
  input  logic [7:0] gmcp_option,
  output step_res_t res
);

  localparam logic [2:0] MODE_NORMAL = 3'd0;
  localparam logic [2:0] MODE_IAC    = 3'd1;
  localparam logic [2:0] MODE_WILL   = 3'd2;
  localparam logic [2:0] MODE_WONT   = 3'd3;
  localparam logic [2:0] MODE_DO     = 3'd4;
  localparam logic [2:0] MODE_DONT   = 3'd5;
  localparam logic [2:0] MODE_SB     = 3'd6;
  localparam logic [2:0] MODE_SBIAC  = 3'd7;

  logic [2:0] mode, mode_next;
  logic in_gmcp_sub, in_gmcp_sub_next;
  logic option_seen, option_seen_next;
  logic payload_nonempty, payload_nonempty_next;
  logic space_seen, space_seen_next;
  logic text_pending, text_pending_next;
  logic gmcp_accepted, gmcp_accepted_next;

  logic [2:0] cnt;
  logic       pb_en;
  logic [7:0] pb_val;
  logic [7:0] b;

  assign b = word.rx_byte;

  always_comb begin
    mode_next             = mode;
    in_gmcp_sub_next      = in_gmcp_sub;
    option_seen_next      = option_seen;
    payload_nonempty_next = payload_nonempty;
    space_seen_next       = space_seen;
    text_pending_next     = text_pending;
    gmcp_accepted_next    = gmcp_accepted;
    res.kind  = '0;
    res.value = '0;
    cnt    = 3'd0;
    pb_en  = 1'b0;
    pb_val = b;

    unique case (mode)
      MODE_NORMAL: begin
        if (b == BYTE_IAC) begin
          mode_next = MODE_IAC;
        end else begin
          res.kind[cnt[1:0]]  = K_TEXT;
          res.value[cnt[1:0]] = b;
          cnt = cnt + 3'd1;
          text_pending_next = 1'b1;
        end
      end
      MODE_IAC: begin
        if (b == BYTE_IAC) begin
          res.kind[cnt[1:0]]  = K_TEXT;
          res.value[cnt[1:0]] = BYTE_IAC;
          cnt = cnt + 3'd1;
          text_pending_next = 1'b1;
          mode_next = MODE_NORMAL;
        end else if (b == BYTE_WILL) begin
          mode_next = MODE_WILL;
        end else if (b == BYTE_WONT) begin
          mode_next = MODE_WONT;
        end else if (b == BYTE_DO) begin
          mode_next = MODE_DO;
        end else if (b == BYTE_DONT) begin
          mode_next = MODE_DONT;
        end else if (b == BYTE_SB) begin
          in_gmcp_sub_next      = 1'b0;
          payload_nonempty_next = 1'b0;
          space_seen_next       = 1'b0;
          option_seen_next      = 1'b0;
          mode_next = MODE_SB;
        end else begin
          mode_next = MODE_NORMAL;
        end
      end
      MODE_WILL, MODE_DO: begin
        // With reply_enable, WILL: DO for GMCP, DONT otherwise. DO: WONT unless GMCP.
        if (mode == MODE_WILL && b == gmcp_option) begin
          gmcp_accepted_next = 1'b1;
        end
        if (reply_enable && (mode == MODE_WILL || b != gmcp_option)) begin
          res.kind[0]  = K_REPLY;
          res.value[0] = BYTE_IAC;
          res.kind[1]  = K_REPLY;
          res.value[1] = (mode == MODE_DO) ? BYTE_WONT :
                         (b == gmcp_option) ? BYTE_DO : BYTE_DONT;
          res.kind[2]  = K_REPLY;
          res.value[2] = b;
          cnt = 3'd3;
        end
        mode_next = MODE_NORMAL;
      end
      MODE_WONT, MODE_DONT: begin
        mode_next = MODE_NORMAL;
      end
      MODE_SB: begin
        if (b == BYTE_IAC) begin
          mode_next = MODE_SBIAC;
        end else if (!option_seen) begin
          in_gmcp_sub_next = (b == gmcp_option);
          option_seen_next = 1'b1;
        end else begin
          pb_en = 1'b1;
        end
      end
      MODE_SBIAC: begin
        if (b == BYTE_SE) begin
          if (in_gmcp_sub && payload_nonempty) begin
            if (text_pending_next) begin
              res.kind[cnt[1:0]]  = K_TEND;
              cnt = cnt + 3'd1;
              text_pending_next = 1'b0;
            end
            res.kind[cnt[1:0]] = K_COMMIT;
            cnt = cnt + 3'd1;
          end
          in_gmcp_sub_next      = 1'b0;
          payload_nonempty_next = 1'b0;
          space_seen_next       = 1'b0;
          mode_next = MODE_NORMAL;
        end else if (b == BYTE_IAC) begin
          pb_en  = 1'b1;
          pb_val = BYTE_IAC;
          mode_next = MODE_SB;
        end else begin
          if (in_gmcp_sub && payload_nonempty) begin
            res.kind[cnt[1:0]] = K_ABORT;
            cnt = cnt + 3'd1;
          end
          in_gmcp_sub_next      = 1'b0;
          payload_nonempty_next = 1'b0;
          space_seen_next       = 1'b0;
          mode_next = MODE_NORMAL;
        end
      end
      default: begin
        mode_next = MODE_NORMAL;
      end
    endcase

    // GMCP payload byte: first space splits package from data.
    if (pb_en && in_gmcp_sub) begin
      if (!space_seen && pb_val == BYTE_SPACE) begin
        space_seen_next = 1'b1;
      end else begin
        res.kind[cnt[1:0]]  = space_seen ? K_DATA : K_PKG;
        res.value[cnt[1:0]] = pb_val;
        cnt = cnt + 3'd1;
      end
      payload_nonempty_next = 1'b1;
    end

    if (word.end_of_call && text_pending_next) begin
      res.kind[cnt[1:0]]  = K_TEND;
      res.value[cnt[1:0]] = 8'd0;
      cnt = cnt + 3'd1;
      text_pending_next = 1'b0;
    end

    res.count   = cnt;
    res.gmcp_on = gmcp_accepted_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode             <= MODE_NORMAL;
      in_gmcp_sub      <= 1'b0;
      option_seen      <= 1'b0;
      payload_nonempty <= 1'b0;
      space_seen       <= 1'b0;
      text_pending     <= 1'b0;
      gmcp_accepted    <= 1'b0;
    end else if (fire) begin
      mode             <= mode_next;
      in_gmcp_sub      <= in_gmcp_sub_next;
      option_seen      <= option_seen_next;
      payload_nonempty <= payload_nonempty_next;
      space_seen       <= space_seen_next;
      text_pending     <= text_pending_next;
      gmcp_accepted    <= gmcp_accepted_next;
    end
  end

endmodule

// ----- src/gsf_res_buf.sv -----
// Result buffer: holds up to four result words of one byte and drains them.
module gsf_res_buf import gsf_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      load,
  input  step_res_t res,
  input  logic      out_ready,
  output logic      out_valid,
  output out_word_t out_word,
  output logic      free
);

  logic [RES_MAX-1:0][2:0] kind;
  logic [RES_MAX-1:0][7:0] value;
  logic                    gmcp_on;
  logic [2:0]              rem;
  logic [1:0]              pos;

  assign out_valid = (rem != 3'd0);
  assign free      = (rem == 3'd0) || (rem == 3'd1 && out_ready);

  assign out_word.kind    = kind[pos];
  assign out_word.value   = value[pos];
  assign out_word.last    = (rem == 3'd1);
  assign out_word.gmcp_on = gmcp_on;

  always_ff @(posedge clk) begin
    if (rst) begin
      rem <= 3'd0;
      pos <= 2'd0;
    end else if (load) begin
      rem <= res.count;
      pos <= 2'd0;
    end else if (out_valid && out_ready) begin
      rem <= rem - 3'd1;
      pos <= pos + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      kind    <= res.kind;
      value   <= res.value;
      gmcp_on <= res.gmcp_on;
    end
  end

endmodule

// ----- src/gsf_checker.sv -----
// Port-level checks for the telnet GMCP stream filter, bound to the top level.
`include "telnet_gmcp_stream_filter_top_defines.svh"

module gsf_checker import gsf_pkg::*; (
  input logic      clk,
  input logic      rst,
  input logic      result_valid,
  input logic      result_ready,
  input out_word_t result
);

  `GSF_ASSERT_NEXT(a_out_hold, result_valid && !result_ready, result_valid && $stable(result))
  `GSF_ASSERT_NOW(a_kind_range, result_valid, result.kind <= K_REPLY)
  `GSF_ASSERT_NOW(a_marker_zero, result_valid && (result.kind == K_TEND || result.kind == K_COMMIT || result.kind == K_ABORT), result.value == 8'd0)
  `GSF_ASSERT_NOW(a_gmcp_sticky, $past(result_valid && result_ready && result.gmcp_on) && result_valid && !$past(rst), result.gmcp_on)

endmodule

bind telnet_gmcp_stream_filter_top gsf_checker u_gsf_checker (
  .clk          (clk),
  .rst          (rst),
  .result_valid (result_valid),
  .result_ready (result_ready),
  .result       (result)
);

// ----- tb/telnet_gmcp_stream_filter_top_tb.sv -----
// Self-checking testbench for the telnet GMCP stream filter with a predicting scoreboard.
`timescale 1ns / 1ps

module telnet_gmcp_stream_filter_top_tb;
  import gsf_pkg::*;

  localparam logic [7:0] CFG_UNUSED_LO = 8'd2;
  localparam logic [7:0] CFG_UNUSED_HI = 8'hFF;

  typedef enum logic [2:0] {
    PM_TEXT, PM_IAC, PM_WILL, PM_WONT, PM_DO, PM_DONT, PM_SUB, PM_SUB_IAC
  } parse_mode_e;

  class gmcp_filter_scoreboard;
    bit          reply_en;
    logic [7:0]  gmcp_opt;
    parse_mode_e mode;
    bit          in_gmcp;
    bit          opt_seen;
    bit          nonempty;
    bit          space_seen;
    bit          text_pend;
    bit          accepted;
    logic [2:0]  step_kind [RES_MAX];
    logic [7:0]  step_val [RES_MAX];
    int          step_n;
    out_word_t   expected_words [$];
    int          errors;
    int          bytes_noted;
    int          words_checked;
    int          kind_count [8];

    function new();
      reply_en = 1'b1;
      gmcp_opt = GMCP_OPTION_RESET;
      mode = PM_TEXT;
      in_gmcp = 0;
      opt_seen = 0;
      nonempty = 0;
      space_seen = 0;
      text_pend = 0;
      accepted = 0;
      errors = 0;
      bytes_noted = 0;
      words_checked = 0;
      foreach (kind_count[i]) kind_count[i] = 0;
    endfunction

    function void set_reg(logic [7:0] idx, logic [7:0] data);
      if (idx == CFG_REPLY_ENABLE) reply_en = data[0];
      else if (idx == CFG_GMCP_OPTION) gmcp_opt = data;
    endfunction

    function void add(logic [2:0] kind, logic [7:0] val);
      if (step_n < RES_MAX) begin
        step_kind[step_n] = kind;
        step_val[step_n] = val;
        step_n++;
      end
    endfunction

    function void queue_reply(logic [7:0] cmd, logic [7:0] opt);
      if (reply_en) begin
        add(K_REPLY, BYTE_IAC);
        add(K_REPLY, cmd);
        add(K_REPLY, opt);
      end
    endfunction

    function void close_text();
      if (text_pend) begin
        add(K_TEND, 8'h00);
        text_pend = 0;
      end
    endfunction

    function void take_payload(logic [7:0] b);
      if (in_gmcp) begin
        if (!space_seen && b == BYTE_SPACE) space_seen = 1;
        else add(space_seen ? K_DATA : K_PKG, b);
        nonempty = 1;
      end
    endfunction

    function void close_sub();
      in_gmcp = 0;
      nonempty = 0;
      space_seen = 0;
    endfunction

    function void note_byte(in_word_t w);
      logic [7:0] b;
      out_word_t  o;
      b = w.rx_byte;
      step_n = 0;
      bytes_noted++;
      case (mode)
        PM_TEXT: begin
          if (b == BYTE_IAC) mode = PM_IAC;
          else begin
            add(K_TEXT, b);
            text_pend = 1;
          end
        end
        PM_IAC: begin
          if (b == BYTE_IAC) begin
            add(K_TEXT, BYTE_IAC);
            text_pend = 1;
            mode = PM_TEXT;
          end else if (b == BYTE_WILL) mode = PM_WILL;
          else if (b == BYTE_WONT) mode = PM_WONT;
          else if (b == BYTE_DO) mode = PM_DO;
          else if (b == BYTE_DONT) mode = PM_DONT;
          else if (b == BYTE_SB) begin
            close_sub();
            opt_seen = 0;
            mode = PM_SUB;
          end else mode = PM_TEXT;
        end
        PM_WILL: begin
          if (b == gmcp_opt) begin
            queue_reply(BYTE_DO, b);
            accepted = 1;
          end else queue_reply(BYTE_DONT, b);
          mode = PM_TEXT;
        end
        PM_DO: begin
          if (b != gmcp_opt) queue_reply(BYTE_WONT, b);
          mode = PM_TEXT;
        end
        PM_WONT, PM_DONT: mode = PM_TEXT;
        PM_SUB: begin
          if (b == BYTE_IAC) mode = PM_SUB_IAC;
          else if (!opt_seen) begin
            in_gmcp = (b == gmcp_opt);
            opt_seen = 1;
          end else take_payload(b);
        end
        PM_SUB_IAC: begin
          if (b == BYTE_SE) begin
            if (in_gmcp && nonempty) begin
              close_text();
              add(K_COMMIT, 8'h00);
            end
            close_sub();
            mode = PM_TEXT;
          end else if (b == BYTE_IAC) begin
            take_payload(BYTE_IAC);
            mode = PM_SUB;
          end else begin
            if (in_gmcp && nonempty) add(K_ABORT, 8'h00);
            close_sub();
            mode = PM_TEXT;
          end
        end
      endcase
      if (w.end_of_call) close_text();
      for (int k = 0; k < step_n; k++) begin
        o.kind = step_kind[k];
        o.value = step_val[k];
        o.last = (k == step_n - 1);
        o.gmcp_on = accepted;
        expected_words.push_back(o);
      end
    endfunction

    function void check_word(out_word_t got);
      out_word_t want;
      words_checked++;
      kind_count[got.kind]++;
      if (expected_words.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected word: kind=%0d value=%02h last=%0d gmcp_on=%0d",
                   got.kind, got.value, got.last, got.gmcp_on);
        return;
      end
      want = expected_words.pop_front();
      if (got.kind !== want.kind || got.value !== want.value ||
          got.last !== want.last || got.gmcp_on !== want.gmcp_on) begin
        errors++;
        if (errors <= 10) begin
          $display("mismatch word %0d: exp kind=%0d value=%02h last=%0d gmcp_on=%0d",
                   words_checked, want.kind, want.value, want.last, want.gmcp_on);
          $display("  got kind=%0d value=%02h last=%0d gmcp_on=%0d",
                   got.kind, got.value, got.last, got.gmcp_on);
        end
      end
    endfunction
  endclass

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       item_valid = 1'b0;
  logic       item_ready;
  in_word_t   item = '0;
  logic       result_valid;
  logic       result_ready = 1'b0;
  out_word_t  result;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [7:0] cfg_index = '0;
  logic [7:0] cfg_data = '0;

  gmcp_filter_scoreboard sb;
  bit src_burst = 0;
  int phase_bytes = 0;
  int settings_used = 0;

  telnet_gmcp_stream_filter_top uut (
    .clk(clk), .rst(rst),
    .item_valid(item_valid), .item_ready(item_ready), .item(item),
    .result_valid(result_valid), .result_ready(result_ready), .result(result),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    if (!rst && result_valid && result_ready) sb.check_word(result);
  end

  // result sink: random short stalls, rare long ones, one long hold-off mid-run
  initial begin
    int  stall_left;
    int  hold_left;
    bit  hold_done;
    int  r;
    stall_left = 0;
    hold_left = 0;
    hold_done = 0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (!hold_done && sb.bytes_noted >= 200) begin
        hold_done = 1;
        hold_left = 300;
      end
      r = $urandom_range(0, 99);
      if (hold_left > 0) begin
        hold_left--;
        result_ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        result_ready <= 1'b0;
      end else if (r < 2) begin
        stall_left = $urandom_range(8, 30);
        result_ready <= 1'b0;
      end else if (r < 12) begin
        stall_left = $urandom_range(0, 2);
        result_ready <= 1'b0;
      end else begin
        result_ready <= 1'b1;
      end
      @(negedge clk);
    end
  end

  function automatic int pick_gap();
    int r;
    if (src_burst) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(6, 25);
  endfunction

  // entered and left just after a falling edge
  task automatic send_byte(logic [7:0] b, logic eoc);
    int       gap;
    in_word_t w;
    gap = pick_gap();
    w.rx_byte = b;
    w.end_of_call = eoc;
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    item <= w;
    item_valid <= 1'b1;
    do @(posedge clk); while (!item_ready);
    sb.note_byte(w);
    phase_bytes++;
    @(negedge clk);
  endtask

  task automatic send_rnd(logic [7:0] b);
    send_byte(b, $urandom_range(0, 5) == 0);
  endtask

  task automatic write_reg(logic [7:0] idx, logic [7:0] data);
    cfg_index <= idx;
    cfg_data <= data;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    sb.set_reg(idx, data);
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic drain();
    item_valid <= 1'b0;
    while (sb.expected_words.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  function automatic logic [7:0] pick_opt();
    if ($urandom_range(0, 1)) return sb.gmcp_opt;
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic send_sequence();
    int         sel;
    int         n;
    int         r;
    logic [7:0] b;
    src_burst = ($urandom_range(0, 3) == 0);
    sel = $urandom_range(0, 99);
    if (sel < 25) begin
      n = $urandom_range(1, 6);
      for (int i = 0; i < n; i++) begin
        if ($urandom_range(0, 9) == 0) begin
          send_rnd(BYTE_IAC);
          send_rnd(BYTE_IAC);
        end else send_rnd(8'($urandom_range(0, 254)));
      end
    end else if (sel < 32) begin
      send_rnd(BYTE_IAC);
      send_rnd(8'($urandom_range(0, 249)));
    end else if (sel < 55) begin
      send_rnd(BYTE_IAC);
      send_rnd(8'(BYTE_WILL + $urandom_range(0, 3)));
      send_rnd(pick_opt());
    end else if (sel < 88) begin
      send_rnd(BYTE_IAC);
      send_rnd(BYTE_SB);
      send_rnd(($urandom_range(0, 9) < 8) ? sb.gmcp_opt : 8'($urandom_range(0, 255)));
      n = $urandom_range(0, 8);
      for (int i = 0; i < n; i++) begin
        r = $urandom_range(0, 99);
        if (r < 25) send_rnd(BYTE_SPACE);
        else if (r < 35) begin
          send_rnd(BYTE_IAC);
          send_rnd(BYTE_IAC);
        end else send_rnd(8'($urandom_range(0, 254)));
      end
      r = $urandom_range(0, 99);
      if (r < 70) begin
        send_rnd(BYTE_IAC);
        send_rnd(BYTE_SE);
      end else if (r < 90) begin
        b = 8'($urandom_range(0, 254));
        if (b == BYTE_SE) b = 8'h01;
        send_rnd(BYTE_IAC);
        send_rnd(b);
      end
    end else begin
      n = $urandom_range(1, 4);
      for (int i = 0; i < n; i++) send_rnd(8'($urandom_range(0, 255)));
    end
  endtask

  initial begin
    logic [8:0] dir_list [];
    sb = new();
    dir_list = '{
      9'h041, 9'h100,                     // text, end of call flushes text
      9'h0FF, 9'h1FF,                     // escaped 0xFF
      9'h0FF, 9'h0F1,                     // two-byte command
      9'h0FF, 9'h0FB, 9'h0C9,             // WILL GMCP
      9'h0FF, 9'h0FB, 9'h018,             // WILL other
      9'h0FF, 9'h0FD, 9'h0C9,             // DO GMCP
      9'h0FF, 9'h0FD, 9'h07F,             // DO other
      9'h0FF, 9'h0FC, 9'h001,
      9'h0FF, 9'h0FE, 9'h001,
      9'h054,                             // pending text before commit
      9'h0FF, 9'h0FA, 9'h0C9, 9'h0FF, 9'h0FF, 9'h020, 9'h080, 9'h0FF, 9'h0F0,
      9'h0FF, 9'h0FA, 9'h0C9, 9'h0FF, 9'h0F0,          // empty message
      9'h0FF, 9'h0FA, 9'h0C9, 9'h041, 9'h0FF, 9'h000,  // abort
      9'h0FF, 9'h0FA, 9'h018, 9'h041, 9'h0FF, 9'h0F0   // other option, dropped
    };
    repeat (6) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    write_reg(CFG_REPLY_ENABLE, 8'd1);
    write_reg(CFG_GMCP_OPTION, GMCP_OPTION_RESET);
    settings_used = 1;
    foreach (dir_list[i]) send_byte(dir_list[i][7:0], dir_list[i][8]);
    drain();

    for (int p = 0; p < 5; p++) begin
      case (p)
        1: begin
          write_reg(CFG_REPLY_ENABLE, 8'd0);
          write_reg(CFG_UNUSED_LO, 8'hFF);
        end
        2: write_reg(CFG_GMCP_OPTION, 8'h00);
        3: begin
          write_reg(CFG_REPLY_ENABLE, 8'hFF);
          write_reg(CFG_GMCP_OPTION, 8'hFF);
          write_reg(CFG_UNUSED_HI, 8'h00);
        end
        4: begin
          write_reg(CFG_REPLY_ENABLE, 8'($urandom_range(0, 255)));
          write_reg(CFG_GMCP_OPTION, 8'($urandom_range(0, 255)));
        end
        default: ;
      endcase
      if (p > 0) settings_used++;
      phase_bytes = 0;
      while (phase_bytes < 100) send_sequence();
      drain();
    end

    begin
      int waited;
      waited = 0;
      while (sb.expected_words.size() != 0 && waited < 20000) begin
        @(negedge clk);
        waited++;
      end
      repeat (10) @(negedge clk);
    end
    if (sb.expected_words.size() != 0) begin
      $display("%0d expected words never arrived", sb.expected_words.size());
      sb.errors += sb.expected_words.size();
    end
    $display("run covered %0d input bytes, %0d result words, %0d register settings",
             sb.bytes_noted, sb.words_checked, settings_used);
    $display("commits %0d, aborts %0d, reply bytes %0d, text ends %0d, mismatches %0d",
             sb.kind_count[K_COMMIT], sb.kind_count[K_ABORT], sb.kind_count[K_REPLY],
             sb.kind_count[K_TEND], sb.errors);
    if (sb.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("timeout");
    $display("DONE: errors detected");
    $finish;
  end

endmodule
